### src/efte_pkg.sv
`default_nettype none

package efte_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int PROG_W        = FRAC_BITS + 1;
    localparam int ELAPSED_SHIFT = FRAC_BITS - 8;
    localparam int DUR_W         = 16;
    localparam int OFF_W         = 22;
    localparam int MAG_W         = OFF_W - 1;
    localparam int CFG_W         = 22;
    localparam int CFG_IDX_W     = 3;

    typedef logic [PROG_W-1:0] t_prog;
    typedef logic [DUR_W-1:0]  t_dur;

    localparam t_prog ONE     = t_prog'(1) << FRAC_BITS;
    localparam t_dur  MAX_DUR = 16'd60000;

    localparam logic signed [OFF_W-1:0] OFF_MAX = 22'sd1048576;
    localparam logic signed [OFF_W-1:0] OFF_MIN = -22'sd1048576;

    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_SHOW    = 3'd1;
    localparam logic [2:0] OP_HIDE    = 3'd2;
    localparam logic [2:0] OP_TOGGLE  = 3'd3;
    localparam logic [2:0] OP_RST_VIS = 3'd4;
    localparam logic [2:0] OP_RST_HID = 3'd5;

    localparam logic [1:0] PH_HIDDEN  = 2'd0;
    localparam logic [1:0] PH_SHOWING = 2'd1;
    localparam logic [1:0] PH_VISIBLE = 2'd2;
    localparam logic [1:0] PH_HIDING  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_SHOW = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIDE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HWS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOFF = 3'd3;

endpackage

`default_nettype wire

### src/efte_div.sv
`default_nettype none

module efte_div #(
    parameter int N_W = 32
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [N_W-1:0]              i_dividend,
    input  wire logic [efte_pkg::DUR_W-1:0]  i_divisor,
    output logic                             o_done,
    output logic [N_W-1:0]                   o_quotient
);

    localparam int CNT_W = $clog2(N_W + 1);
    localparam int DW    = efte_pkg::DUR_W;

    logic [N_W-1:0]   r_q, n_q;
    logic [DW-1:0]    r_rem, n_rem;
    logic [DW-1:0]    r_d;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [DW:0]      w_trial;
    logic [DW:0]      w_diff;
    logic             w_ge;

    // One quotient bit per cycle by restoring division.
    assign w_trial = {r_rem, r_q[N_W-1]};
    assign w_diff  = w_trial - {1'b0, r_d};
    assign w_ge    = w_trial >= {1'b0, r_d};

    always_comb begin
        n_q    = r_q;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_q    = i_dividend;
            n_rem  = '0;
            n_cnt  = CNT_W'(N_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_q   = {r_q[N_W-2:0], w_ge};
            n_rem = w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q   <= n_q;
        r_rem <= n_rem;
        if (i_start) begin
            r_d <= i_divisor;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

`default_nettype wire

### src/efte_mul.sv
`default_nettype none

module efte_mul #(
    parameter int A_W = 17
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [A_W-1:0]                i_a,
    input  wire logic [efte_pkg::PROG_W-1:0]   i_b,
    output logic                               o_done,
    output logic [A_W:0]                       o_result
);

    localparam int B_W   = efte_pkg::PROG_W;
    localparam int CNT_W = $clog2(B_W + 1);
    localparam logic [A_W-1:0] L_HALF = A_W'(1) << (efte_pkg::FRAC_BITS - 1);

    logic [A_W-1:0]   r_a;
    logic [A_W-1:0]   r_hi, n_hi;
    logic [B_W-1:0]   r_lo, n_lo;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [A_W:0]     w_sum;
    logic [A_W+B_W-1:0] w_full;

    // Shift-add multiplier, one multiplier bit per cycle. The high half starts
    // at one half of the final weight, so the product comes out rounded half up.
    assign w_sum  = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_a} : '0);
    assign w_full = {r_hi, r_lo};

    always_comb begin
        n_hi   = r_hi;
        n_lo   = r_lo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_hi   = L_HALF;
            n_lo   = i_b;
            n_cnt  = CNT_W'(B_W);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_hi  = w_sum[A_W:1];
            n_lo  = {w_sum[0], r_lo[B_W-1:1]};
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi <= n_hi;
        r_lo <= n_lo;
        if (i_start) begin
            r_a <= i_a;
        end
    end

    assign o_done   = r_done;
    assign o_result = w_full[A_W+B_W-1:efte_pkg::FRAC_BITS];

endmodule

`default_nettype wire

### src/eased_fade_transition_engine.sv
// Show/hide fade controller. Each input word carries an opcode (tick, show, hide,
// toggle, reset visible, reset hidden, query) and an elapsed time in ms Q8; each
// one yields exactly one result word with the phase, the linear progress, the
// ease-out-cubic motion value, the ease-out-quart width scale and the offset.
// Both channels use valid/ready. Registers are written through a plain write
// port and must only be written while no word is in flight.
// A word that does not advance the ramp runs three rounds of the bit-serial
// multipliers and then loads the output register. A tick that moves the ramp
// first runs the bit-serial divider. One word is processed at a time, and the
// engine returns to idle to accept the next word once the previous result has
// been placed in the output register, even if that result is still waiting.
// When the receiver stalls, the result holds in the output register and a
// following word stalls once its own result is ready.
// Reset clears the phase to hidden, the progress to zero, both durations to
// zero, the hidden width scale to one and the hidden offset to zero.
`default_nettype none

module eased_fade_transition_engine #(
    parameter int ELAPSED_BITS = 24
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [2:0]                        i_opcode,
    input  wire logic [ELAPSED_BITS-1:0]           i_elapsed,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [1:0]                             o_phase,
    output logic [16:0]                            o_linear_progress,
    output logic [16:0]                            o_motion_progress,
    output logic [16:0]                            o_width_scale,
    output logic signed [21:0]                     o_vertical_offset,
    output logic                                   o_is_animating,
    output logic                                   o_should_present,
    output logic                                   o_target_visible,
    input  wire logic                              i_cfg_we,
    input  wire logic [efte_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [efte_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int N_W   = ELAPSED_BITS + efte_pkg::ELAPSED_SHIFT;
    localparam int PW    = efte_pkg::PROG_W;
    localparam int DW    = efte_pkg::DUR_W;
    localparam int OW    = efte_pkg::OFF_W;
    localparam int MW    = efte_pkg::MAG_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_M1   = 3'd2;
    localparam logic [2:0] S_M2   = 3'd3;
    localparam logic [2:0] S_M3   = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    function automatic efte_pkg::t_dur f_clamp_dur(input efte_pkg::t_dur d);
        return (d > efte_pkg::MAX_DUR) ? efte_pkg::MAX_DUR : d;
    endfunction

    logic [2:0]            r_state, n_state;
    logic                  r_launch, n_launch;
    logic [1:0]            r_phase, n_phase;
    efte_pkg::t_prog       r_prog, n_prog;
    efte_pkg::t_dur        r_show, n_show;
    efte_pkg::t_dur        r_hide, n_hide;
    efte_pkg::t_prog       r_hws, n_hws;
    logic signed [OW-1:0]  r_hoff, n_hoff;
    efte_pkg::t_prog       r_r2, r_r3, r_r4;
    logic                  r_out_valid, n_out_valid;

    logic [1:0]            r_o_phase;
    efte_pkg::t_prog       r_o_lin, r_o_mot, r_o_wid;
    logic [OW-1:0]         r_o_off;
    logic                  r_o_anim, r_o_pres, r_o_tgt;

    logic                  w_accept;
    logic                  w_out_load;
    logic                  w_div_start;
    logic                  w_div_done;
    logic [N_W-1:0]        w_quot;
    efte_pkg::t_dur        w_divisor;
    logic                  w_u0_done, w_u1_done;
    efte_pkg::t_prog       w_u0_a, w_u0_b, w_u1_b;
    logic [MW-1:0]         w_u1_a;
    logic [PW:0]           w_u0_res;
    logic [MW:0]           w_u1_res;
    efte_pkg::t_prog       w_p, w_r, w_hws, w_omh;
    logic signed [OW-1:0]  w_off_c;
    logic [OW-1:0]         w_mag_full;
    logic [MW-1:0]         w_mag;
    logic [PW:0]           w_width_sum;
    logic [OW-1:0]         w_offm;
    logic                  w_tgt;
    logic                  w_do_tgt;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_out_load  = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    assign w_p   = (r_prog > efte_pkg::ONE) ? efte_pkg::ONE : r_prog;
    assign w_r   = efte_pkg::ONE - w_p;
    assign w_hws = (r_hws > efte_pkg::ONE) ? efte_pkg::ONE : r_hws;
    assign w_omh = efte_pkg::ONE - w_hws;

    always_comb begin
        priority if (r_hoff > efte_pkg::OFF_MAX) begin
            w_off_c = efte_pkg::OFF_MAX;
        end else if (r_hoff < efte_pkg::OFF_MIN) begin
            w_off_c = efte_pkg::OFF_MIN;
        end else begin
            w_off_c = r_hoff;
        end
    end

    assign w_mag_full = w_off_c[OW-1] ? OW'(-w_off_c) : OW'(w_off_c);
    assign w_mag      = w_mag_full[MW-1:0];

    assign w_divisor = (r_phase == efte_pkg::PH_SHOWING) ? f_clamp_dur(r_show)
                                                         : f_clamp_dur(r_hide);

    always_comb begin
        unique case (r_state)
            S_M1: begin
                w_u0_a = w_r;
                w_u0_b = w_r;
                w_u1_a = MW'(r_r2);
                w_u1_b = r_r2;
            end
            S_M3: begin
                w_u0_a = w_omh;
                w_u0_b = efte_pkg::ONE - r_r4;
                w_u1_a = w_mag;
                w_u1_b = r_r3;
            end
            default: begin
                w_u0_a = r_r2;
                w_u0_b = w_r;
                w_u1_a = MW'(r_r2);
                w_u1_b = r_r2;
            end
        endcase
    end

    efte_div #(
        .N_W (N_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend ({i_elapsed, {efte_pkg::ELAPSED_SHIFT{1'b0}}}),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    efte_mul #(
        .A_W (PW)
    ) u_mul0 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_launch),
        .i_a      (w_u0_a),
        .i_b      (w_u0_b),
        .o_done   (w_u0_done),
        .o_result (w_u0_res)
    );

    efte_mul #(
        .A_W (MW)
    ) u_mul1 (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_launch),
        .i_a      (w_u1_a),
        .i_b      (w_u1_b),
        .o_done   (w_u1_done),
        .o_result (w_u1_res)
    );

    always_comb begin
        n_show = r_show;
        n_hide = r_hide;
        n_hws  = r_hws;
        n_hoff = r_hoff;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                efte_pkg::CFG_SHOW: n_show = i_cfg_data[DW-1:0];
                efte_pkg::CFG_HIDE: n_hide = i_cfg_data[DW-1:0];
                efte_pkg::CFG_HWS:  n_hws  = i_cfg_data[PW-1:0];
                efte_pkg::CFG_HOFF: n_hoff = i_cfg_data[OW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_launch    = 1'b0;
        n_phase     = r_phase;
        n_prog      = r_prog;
        n_out_valid = r_out_valid && !i_out_ready;
        w_div_start = 1'b0;
        w_tgt       = 1'b0;
        w_do_tgt    = 1'b0;

        if (i_cfg_we && (i_cfg_index <= efte_pkg::CFG_HOFF)) begin
            if (r_phase == efte_pkg::PH_SHOWING && n_show == '0) begin
                n_phase = efte_pkg::PH_VISIBLE;
                n_prog  = efte_pkg::ONE;
            end else if (r_phase == efte_pkg::PH_HIDING && n_hide == '0) begin
                n_phase = efte_pkg::PH_HIDDEN;
                n_prog  = '0;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state  = S_M1;
                    n_launch = 1'b1;
                    unique case (i_opcode)
                        efte_pkg::OP_TICK: begin
                            if (i_elapsed != '0) begin
                                if (r_phase == efte_pkg::PH_SHOWING) begin
                                    if (r_show == '0) begin
                                        n_phase = efte_pkg::PH_VISIBLE;
                                        n_prog  = efte_pkg::ONE;
                                    end else begin
                                        w_div_start = 1'b1;
                                        n_state     = S_DIV;
                                        n_launch    = 1'b0;
                                    end
                                end else if (r_phase == efte_pkg::PH_HIDING) begin
                                    if (r_hide == '0) begin
                                        n_phase = efte_pkg::PH_HIDDEN;
                                        n_prog  = '0;
                                    end else begin
                                        w_div_start = 1'b1;
                                        n_state     = S_DIV;
                                        n_launch    = 1'b0;
                                    end
                                end
                            end
                        end
                        efte_pkg::OP_SHOW: begin
                            w_do_tgt = 1'b1;
                            w_tgt    = 1'b1;
                        end
                        efte_pkg::OP_HIDE: begin
                            w_do_tgt = 1'b1;
                            w_tgt    = 1'b0;
                        end
                        efte_pkg::OP_TOGGLE: begin
                            w_do_tgt = 1'b1;
                            w_tgt    = !(r_phase == efte_pkg::PH_SHOWING ||
                                         r_phase == efte_pkg::PH_VISIBLE);
                        end
                        efte_pkg::OP_RST_VIS: begin
                            n_phase = efte_pkg::PH_VISIBLE;
                            n_prog  = efte_pkg::ONE;
                        end
                        efte_pkg::OP_RST_HID: begin
                            n_phase = efte_pkg::PH_HIDDEN;
                            n_prog  = '0;
                        end
                        default: ;
                    endcase
                    if (w_do_tgt) begin
                        if (w_tgt) begin
                            if (r_prog >= efte_pkg::ONE || r_show == '0) begin
                                n_phase = efte_pkg::PH_VISIBLE;
                                n_prog  = efte_pkg::ONE;
                            end else begin
                                n_phase = efte_pkg::PH_SHOWING;
                            end
                        end else begin
                            if (r_prog == '0 || r_hide == '0) begin
                                n_phase = efte_pkg::PH_HIDDEN;
                                n_prog  = '0;
                            end else begin
                                n_phase = efte_pkg::PH_HIDING;
                            end
                        end
                    end
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state  = S_M1;
                    n_launch = 1'b1;
                    if (r_phase == efte_pkg::PH_SHOWING) begin
                        if (w_quot >= N_W'(efte_pkg::ONE - r_prog)) begin
                            n_phase = efte_pkg::PH_VISIBLE;
                            n_prog  = efte_pkg::ONE;
                        end else begin
                            n_prog = r_prog + w_quot[PW-1:0];
                        end
                    end else begin
                        if (w_quot >= N_W'(r_prog)) begin
                            n_phase = efte_pkg::PH_HIDDEN;
                            n_prog  = '0;
                        end else begin
                            n_prog = r_prog - w_quot[PW-1:0];
                        end
                    end
                end
            end
            S_M1: begin
                if (w_u0_done) begin
                    n_state  = S_M2;
                    n_launch = 1'b1;
                end
            end
            S_M2: begin
                if (w_u0_done && w_u1_done) begin
                    n_state  = S_M3;
                    n_launch = 1'b1;
                end
            end
            S_M3: begin
                if (w_u0_done && w_u1_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_load) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_launch    <= 1'b0;
            r_phase     <= efte_pkg::PH_HIDDEN;
            r_prog      <= '0;
            r_show      <= '0;
            r_hide      <= '0;
            r_hws       <= efte_pkg::ONE;
            r_hoff      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_launch    <= n_launch;
            r_phase     <= n_phase;
            r_prog      <= n_prog;
            r_show      <= n_show;
            r_hide      <= n_hide;
            r_hws       <= n_hws;
            r_hoff      <= n_hoff;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_M1 && w_u0_done) begin
            r_r2 <= w_u0_res[PW-1:0];
        end
        if (r_state == S_M2 && w_u0_done) begin
            r_r3 <= w_u0_res[PW-1:0];
            r_r4 <= w_u1_res[PW-1:0];
        end
    end

    assign w_width_sum = {1'b0, w_hws} + {1'b0, w_u0_res[PW-1:0]};
    assign w_offm      = w_u1_res[OW-1:0];

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_o_phase <= r_phase;
            r_o_lin   <= w_p;
            r_o_mot   <= efte_pkg::ONE - r_r3;
            r_o_wid   <= w_width_sum[PW-1:0];
            r_o_off   <= w_off_c[OW-1] ? (OW'(0) - w_offm) : w_offm;
            r_o_anim  <= (r_phase == efte_pkg::PH_SHOWING) ||
                         (r_phase == efte_pkg::PH_HIDING);
            r_o_pres  <= (r_phase != efte_pkg::PH_HIDDEN);
            r_o_tgt   <= (r_phase == efte_pkg::PH_SHOWING) ||
                         (r_phase == efte_pkg::PH_VISIBLE);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_phase           = r_o_phase;
    assign o_linear_progress = r_o_lin;
    assign o_motion_progress = r_o_mot;
    assign o_width_scale     = r_o_wid;
    assign o_vertical_offset = $signed(r_o_off);
    assign o_is_animating    = r_o_anim;
    assign o_should_present  = r_o_pres;
    assign o_target_visible  = r_o_tgt;

endmodule

`default_nettype wire

### src/efte_check.sv
`default_nettype none

module efte_check (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [1:0]  o_phase,
    input wire logic [16:0] o_linear_progress,
    input wire logic        o_is_animating,
    input wire logic        o_should_present,
    input wire logic        o_target_visible
);

    // A word is worked on alone, so ready drops right after it is taken.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted while a word is still in work");

    a_flags_match_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_is_animating == (o_phase == efte_pkg::PH_SHOWING ||
                                o_phase == efte_pkg::PH_HIDING)) &&
            (o_should_present == (o_phase != efte_pkg::PH_HIDDEN)) &&
            (o_target_visible == (o_phase == efte_pkg::PH_SHOWING ||
                                  o_phase == efte_pkg::PH_VISIBLE)))
        else $error("status flags disagree with the phase");

    a_settled_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_phase != efte_pkg::PH_VISIBLE || o_linear_progress == efte_pkg::ONE) &&
            (o_phase != efte_pkg::PH_HIDDEN || o_linear_progress == 17'd0))
        else $error("settled phase with progress off its end point");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_phase) && $stable(o_linear_progress)))
        else $error("stalled result word changed");

endmodule

bind eased_fade_transition_engine efte_check u_efte_check (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_in_valid),
    .o_in_ready        (o_in_ready),
    .o_out_valid       (o_out_valid),
    .i_out_ready       (i_out_ready),
    .o_phase           (o_phase),
    .o_linear_progress (o_linear_progress),
    .o_is_animating    (o_is_animating),
    .o_should_present  (o_should_present),
    .o_target_visible  (o_target_visible)
);

`default_nettype wire

### tb/sv/eased_fade_transition_engine_tb.sv
`timescale 1ns / 100ps

module eased_fade_transition_engine_tb;

    localparam int          ELAPSED_W      = 24;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          SETTLE_CYCLES  = 100;
    localparam logic [2:0]  OP_QUERY       = 3'd6;
    localparam logic [2:0]  OP_SPARE       = 3'd7;
    localparam logic [63:0] UNIT           = 64'd1 << efte_pkg::FRAC_BITS;
    localparam logic [63:0] HALF_UNIT      = 64'd1 << (efte_pkg::FRAC_BITS - 1);
    localparam longint      OFF_LIMIT      = 1048576;

    typedef struct packed {
        logic [2:0]           op;
        logic [ELAPSED_W-1:0] elapsed;
    } t_fade_cmd;

    typedef struct packed {
        logic [1:0]  phase;
        logic [16:0] lin;
        logic [16:0] motion;
        logic [16:0] width;
        logic [21:0] voff;
        logic        anim;
        logic        present;
        logic        target;
    } t_fade_view;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_in_valid;
    logic                            o_in_ready;
    logic [2:0]                      i_opcode;
    logic [ELAPSED_W-1:0]            i_elapsed;
    logic                            o_out_valid;
    logic                            i_out_ready;
    logic [1:0]                      o_phase;
    logic [16:0]                     o_linear_progress;
    logic [16:0]                     o_motion_progress;
    logic [16:0]                     o_width_scale;
    logic signed [21:0]              o_vertical_offset;
    logic                            o_is_animating;
    logic                            o_should_present;
    logic                            o_target_visible;
    logic                            i_cfg_we;
    logic [efte_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [efte_pkg::CFG_W-1:0]      i_cfg_data;

    eased_fade_transition_engine #(
        .ELAPSED_BITS(ELAPSED_W)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_opcode          (i_opcode),
        .i_elapsed         (i_elapsed),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_phase           (o_phase),
        .o_linear_progress (o_linear_progress),
        .o_motion_progress (o_motion_progress),
        .o_width_scale     (o_width_scale),
        .o_vertical_offset (o_vertical_offset),
        .o_is_animating    (o_is_animating),
        .o_should_present  (o_should_present),
        .o_target_visible  (o_target_visible),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    t_fade_cmd   pending_cmds[$];
    t_fade_view  awaited_views[$];
    int unsigned mismatch_count;
    int unsigned idle_cycles;
    logic        word_taken;
    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned rx_mode;
    int unsigned rx_left;

    logic [1:0]         fade_phase;
    logic [16:0]        fade_prog;
    logic [15:0]        show_ms;
    logic [15:0]        hide_ms;
    logic [16:0]        hidden_ws;
    logic signed [21:0] hidden_off;

    function automatic logic [15:0] sat_dur(logic [15:0] d);
        return (d > efte_pkg::MAX_DUR) ? efte_pkg::MAX_DUR : d;
    endfunction

    function automatic void settle_fade(bit vis);
        fade_prog  = vis ? efte_pkg::ONE : '0;
        fade_phase = vis ? efte_pkg::PH_VISIBLE : efte_pkg::PH_HIDDEN;
    endfunction

    function automatic void aim_fade(bit vis);
        if (vis) begin
            if (fade_prog >= efte_pkg::ONE || sat_dur(show_ms) == 0) settle_fade(1'b1);
            else fade_phase = efte_pkg::PH_SHOWING;
        end else begin
            if (fade_prog == 0 || sat_dur(hide_ms) == 0) settle_fade(1'b0);
            else fade_phase = efte_pkg::PH_HIDING;
        end
    endfunction

    function automatic void advance_fade(logic [ELAPSED_W-1:0] el);
        logic [63:0] step;
        logic [15:0] dur;
        if (el == 0) return;
        if (fade_phase == efte_pkg::PH_SHOWING) begin
            dur = sat_dur(show_ms);
            if (dur == 0) begin
                settle_fade(1'b1);
            end else begin
                step = (64'(el) << efte_pkg::ELAPSED_SHIFT) / dur;
                if (step >= UNIT - fade_prog) settle_fade(1'b1);
                else fade_prog = fade_prog + step[16:0];
            end
        end else if (fade_phase == efte_pkg::PH_HIDING) begin
            dur = sat_dur(hide_ms);
            if (dur == 0) begin
                settle_fade(1'b0);
            end else begin
                step = (64'(el) << efte_pkg::ELAPSED_SHIFT) / dur;
                if (step >= 64'(fade_prog)) settle_fade(1'b0);
                else fade_prog = fade_prog - step[16:0];
            end
        end
    endfunction

    function automatic void apply_cfg_write(logic [2:0] idx, logic [21:0] data);
        case (idx)
            efte_pkg::CFG_SHOW: show_ms    = data[15:0];
            efte_pkg::CFG_HIDE: hide_ms    = data[15:0];
            efte_pkg::CFG_HWS:  hidden_ws  = data[16:0];
            efte_pkg::CFG_HOFF: hidden_off = data;
            default:            return;
        endcase
        if (fade_phase == efte_pkg::PH_SHOWING && sat_dur(show_ms) == 0)
            settle_fade(1'b1);
        else if (fade_phase == efte_pkg::PH_HIDING && sat_dur(hide_ms) == 0)
            settle_fade(1'b0);
    endfunction

    function automatic t_fade_view predict_view(t_fade_cmd c);
        logic [63:0] p;
        logic [63:0] r;
        logic [63:0] r2;
        logic [63:0] r3;
        logic [63:0] r4;
        logic [63:0] hws;
        logic [63:0] mag;
        logic [63:0] offmag;
        longint      off;
        t_fade_view  v;
        case (c.op)
            efte_pkg::OP_TICK:    advance_fade(c.elapsed);
            efte_pkg::OP_SHOW:    aim_fade(1'b1);
            efte_pkg::OP_HIDE:    aim_fade(1'b0);
            efte_pkg::OP_TOGGLE:  aim_fade(!(fade_phase == efte_pkg::PH_SHOWING ||
                                             fade_phase == efte_pkg::PH_VISIBLE));
            efte_pkg::OP_RST_VIS: settle_fade(1'b1);
            efte_pkg::OP_RST_HID: settle_fade(1'b0);
            default: ;
        endcase
        p  = (64'(fade_prog) > UNIT) ? UNIT : 64'(fade_prog);
        r  = UNIT - p;
        r2 = (r * r + HALF_UNIT) >> efte_pkg::FRAC_BITS;
        r3 = (r2 * r + HALF_UNIT) >> efte_pkg::FRAC_BITS;
        r4 = (r2 * r2 + HALF_UNIT) >> efte_pkg::FRAC_BITS;
        hws = (64'(hidden_ws) > UNIT) ? UNIT : 64'(hidden_ws);
        off = longint'(hidden_off);
        if (off > OFF_LIMIT) off = OFF_LIMIT;
        if (off < -OFF_LIMIT) off = -OFF_LIMIT;
        mag = (off < 0) ? 64'(-off) : 64'(off);
        offmag = (mag * r3 + HALF_UNIT) >> efte_pkg::FRAC_BITS;
        v.phase   = fade_phase;
        v.lin     = p[16:0];
        v.motion  = 17'(UNIT - r3);
        v.width   = 17'(hws + (((UNIT - hws) * (UNIT - r4) + HALF_UNIT)
                               >> efte_pkg::FRAC_BITS));
        v.voff    = (off < 0) ? 22'(-offmag) : 22'(offmag);
        v.anim    = (fade_phase == efte_pkg::PH_SHOWING ||
                     fade_phase == efte_pkg::PH_HIDING);
        v.present = (fade_phase != efte_pkg::PH_HIDDEN);
        v.target  = (fade_phase == efte_pkg::PH_SHOWING ||
                     fade_phase == efte_pkg::PH_VISIBLE);
        return v;
    endfunction

    task automatic check_field(string fname, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            mismatch_count++;
        end
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [21:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        apply_cfg_write(idx, data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic write_settings(logic [15:0] s, logic [15:0] h, logic [16:0] w,
                                  logic [21:0] o);
        cfg_write(efte_pkg::CFG_SHOW, {6'($urandom), s});
        cfg_write(efte_pkg::CFG_HIDE, {6'($urandom), h});
        cfg_write(efte_pkg::CFG_HWS, {5'($urandom), w});
        cfg_write(efte_pkg::CFG_HOFF, o);
        cfg_write(3'($urandom_range(4, 7)), 22'($urandom));
    endtask

    task automatic push_cmd(logic [2:0] op, logic [ELAPSED_W-1:0] el);
        pending_cmds.push_back('{op, el});
    endtask

    // Block until every word has gone through and the engine has had time to go idle.
    task automatic wait_quiet();
        while (pending_cmds.size() != 0 || i_in_valid || awaited_views.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic fill_random(int unsigned count);
        int unsigned span;
        int unsigned added;
        int unsigned k;
        logic [15:0] slow;
        logic [2:0]  op;
        slow  = (sat_dur(show_ms) > sat_dur(hide_ms)) ? sat_dur(show_ms) : sat_dur(hide_ms);
        span  = (slow == 0) ? 256 : slow * 64;
        added = 0;
        while (added < count) begin
            if ($urandom_range(0, 4) != 0) begin
                case ($urandom_range(0, 2))
                    0:       op = efte_pkg::OP_SHOW;
                    1:       op = efte_pkg::OP_HIDE;
                    default: op = efte_pkg::OP_TOGGLE;
                endcase
                push_cmd(op, 24'($urandom));
                added++;
                k = $urandom_range(2, 14);
                repeat (k) begin
                    case ($urandom_range(0, 11))
                        0: push_cmd(efte_pkg::OP_TICK, '0);
                        1: push_cmd(efte_pkg::OP_TICK, 24'($urandom));
                        2: push_cmd(efte_pkg::OP_TICK, 24'($urandom_range(1, 255)));
                        3: push_cmd($urandom_range(0, 1) ? OP_QUERY : OP_SPARE,
                                    24'($urandom));
                        default: push_cmd(efte_pkg::OP_TICK, 24'($urandom_range(1, span)));
                    endcase
                    added++;
                end
            end else begin
                push_cmd(3'($urandom_range(0, 7)), 24'($urandom));
                added++;
            end
        end
    endtask

    initial begin
        i_clk = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        logic      nv;
        logic      rdy;
        t_fade_cmd nxt;
        nv = 1'b0;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else if (i_in_valid && !word_taken) begin
            nv = 1'b1;
        end else if (gap_left != 0) begin
            gap_left--;
        end else if (pending_cmds.size() != 0) begin
            nxt = pending_cmds.pop_front();
            nv  = 1'b1;
            i_opcode  <= nxt.op;
            i_elapsed <= nxt.elapsed;
            if (burst_left > 1) begin
                burst_left--;
            end else if ($urandom_range(0, 3) == 0) begin
                burst_left = $urandom_range(40, 120);
                gap_left   = 0;
            end else begin
                burst_left = $urandom_range(1, 16);
                gap_left   = $urandom_range(1, 12);
            end
        end
        i_in_valid <= nv;

        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(30, 150);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            0:       rdy = 1'b1;
            1:       rdy = 1'($urandom_range(0, 1));
            2:       rdy = ($urandom_range(0, 5) == 0);
            default: rdy = ((rx_left % 8) < 3);
        endcase
        i_out_ready <= rdy;
    end

    always @(posedge i_clk) begin
        t_fade_view want;
        if (!i_rst_n) begin
            word_taken <= 1'b0;
        end else begin
            word_taken <= i_in_valid && o_in_ready;
            if (o_out_valid && i_out_ready) begin
                if (awaited_views.size() == 0) begin
                    $display("%0t: result word with nothing expected, expected none, actual phase %0d",
                             $time, o_phase);
                    mismatch_count++;
                end else begin
                    want = awaited_views.pop_front();
                    check_field("phase", want.phase, o_phase);
                    check_field("linear_progress", want.lin, o_linear_progress);
                    check_field("motion_progress", want.motion, o_motion_progress);
                    check_field("width_scale", want.width, o_width_scale);
                    check_field("vertical_offset", longint'($signed(want.voff)),
                                longint'(o_vertical_offset));
                    check_field("is_animating", want.anim, o_is_animating);
                    check_field("should_present", want.present, o_should_present);
                    check_field("target_visible", want.target, o_target_visible);
                end
            end
            if (i_in_valid && o_in_ready)
                awaited_views.push_back(predict_view('{i_opcode, i_elapsed}));
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [15:0] s;
        logic [15:0] h;
        logic [16:0] w;
        logic [21:0] o;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_opcode       = efte_pkg::OP_TICK;
        i_elapsed      = '0;
        i_out_ready    = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = efte_pkg::CFG_SHOW;
        i_cfg_data     = '0;
        mismatch_count = 0;
        idle_cycles    = 0;
        burst_left     = 1;
        gap_left       = 0;
        rx_mode        = 0;
        rx_left        = 0;
        fade_phase     = efte_pkg::PH_HIDDEN;
        fade_prog      = '0;
        show_ms        = '0;
        hide_ms        = '0;
        hidden_ws      = efte_pkg::ONE;
        hidden_off     = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: both ramps are instant.
        push_cmd(OP_QUERY, 24'hFFFFFF);
        push_cmd(OP_SPARE, '0);
        push_cmd(efte_pkg::OP_TICK, 24'hFFFFFF);
        push_cmd(efte_pkg::OP_SHOW, '0);
        push_cmd(efte_pkg::OP_HIDE, '0);
        push_cmd(efte_pkg::OP_TOGGLE, '0);
        push_cmd(efte_pkg::OP_TOGGLE, '0);
        push_cmd(efte_pkg::OP_RST_VIS, '0);
        push_cmd(efte_pkg::OP_TICK, 24'd100);
        push_cmd(efte_pkg::OP_RST_HID, '0);
        push_cmd(efte_pkg::OP_TICK, '0);
        wait_quiet();

        write_settings(16'd1000, 16'd300, 17'd0, 22'h300000);
        push_cmd(efte_pkg::OP_SHOW, '0);
        push_cmd(efte_pkg::OP_TICK, 24'd1);
        push_cmd(efte_pkg::OP_TICK, 24'd64000);
        push_cmd(efte_pkg::OP_TOGGLE, '0);
        push_cmd(efte_pkg::OP_TICK, 24'd25600);
        push_cmd(efte_pkg::OP_SHOW, '0);
        push_cmd(efte_pkg::OP_TICK, 24'hFFFFFF);
        push_cmd(efte_pkg::OP_SHOW, '0);
        push_cmd(efte_pkg::OP_HIDE, '0);
        push_cmd(efte_pkg::OP_TICK, 24'hFFFFFF);
        push_cmd(efte_pkg::OP_HIDE, '0);
        push_cmd(efte_pkg::OP_SHOW, '0);
        wait_quiet();
        // A ramp in progress completes as soon as its duration is cleared.
        cfg_write(efte_pkg::CFG_SHOW, '0);
        push_cmd(OP_QUERY, '0);
        push_cmd(efte_pkg::OP_HIDE, '0);
        wait_quiet();
        cfg_write(efte_pkg::CFG_HIDE, '0);
        push_cmd(OP_QUERY, '0);
        wait_quiet();

        for (int k = 0; k < 8; k++) begin
            case (k)
                0: begin s = 16'd60000; h = 16'd60000; w = 17'd65536; o = 22'h100000; end
                1: begin s = 16'd65535; h = 16'd1; w = 17'h1FFFF; o = 22'h1FFFFF; end
                2: begin s = 16'd1; h = 16'd65535; w = 17'd0; o = 22'h200000; end
                3: begin s = 16'd16; h = 16'd250; w = 17'($urandom); o = 22'($urandom); end
                4: begin
                    s = 16'($urandom); h = 16'($urandom);
                    w = 17'($urandom); o = 22'($urandom);
                end
                5: begin s = 16'd0; h = 16'd500; w = 17'd32768; o = 22'h3FFFFF; end
                6: begin s = 16'd300; h = 16'd0; w = 17'($urandom); o = 22'($urandom); end
                default: begin s = 16'd120; h = 16'd3000; w = 17'd65535; o = 22'h300000; end
            endcase
            write_settings(s, h, w, o);
            fill_random(112);
            wait_quiet();
        end

        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
